[design/nirt_pkg.sv]
// Package: shared types, constants and register indexes of the NEC IR transmitter.
package nirt_pkg;

   localparam int DEFAULT_TIMER_WIDTH = 14;
   localparam int CSR_DATA_WIDTH      = 14;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int QUEUE_DEPTH         = 2;
   localparam int QUEUE_PTR_WIDTH     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);
   localparam int FRAME_BITS          = 32;
   localparam int BIT_INDEX_WIDTH     = $clog2(FRAME_BITS);

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEAT_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_ADDR   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HDR_MARK      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HDR_SPACE     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_MARK      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_SPACE     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_SPACE    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP           = 3'd7;

   // register reset values
   localparam logic [7:0]  RST_REPEAT_COUNT = 8'd50;
   localparam logic [7:0]  RST_DEVICE_ADDR  = 8'hF2;
   localparam logic [13:0] RST_HDR_MARK     = 14'd9000;
   localparam logic [13:0] RST_HDR_SPACE    = 14'd4500;
   localparam logic [13:0] RST_BIT_MARK     = 14'd560;
   localparam logic [13:0] RST_ONE_SPACE    = 14'd1693;
   localparam logic [13:0] RST_ZERO_SPACE   = 14'd560;
   localparam logic [13:0] RST_GAP          = 14'd9000;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HDR_MARK  = 3'd1,
      PH_HDR_SPACE = 3'd2,
      PH_BIT_MARK  = 3'd3,
      PH_BIT_SPACE = 3'd4,
      PH_END_MARK  = 3'd5,
      PH_GAP       = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0]  repeat_count;
      logic [7:0]  device_address;
      logic [13:0] header_mark_ticks;
      logic [13:0] header_space_ticks;
      logic [13:0] bit_mark_ticks;
      logic [13:0] one_space_ticks;
      logic [13:0] zero_space_ticks;
      logic [13:0] gap_ticks;
   } csr_type;

   // one tick as it leaves the front end
   typedef struct packed {
      logic       start;
      logic [7:0] data_byte;
   } tick_item_type;

   typedef struct packed {
      logic          valid;
      tick_item_type item;
   } queue_out_type;

endpackage

[design/nirt_channels.sv]
// Interfaces: request and response channels with valid/ready handshake.
interface nirt_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [7:0] data_byte;

   modport source (output valid, output start_req, output data_byte, input ready);
   modport sink   (input valid, input start_req, input data_byte, output ready);
endinterface

interface nirt_rsp_if;
   logic valid;
   logic ready;
   logic carrier_on;
   logic busy_res;

   modport source (output valid, output carrier_on, output busy_res, input ready);
   modport sink   (input valid, input carrier_on, input busy_res, output ready);
endinterface

[design/nirt_front.sv]
// Front end: accepts tick transactions, classifies them and queues them for the sequencer.
module nirt_front (
   input  logic                   clock,
   input  logic                   reset,
   nirt_req_if.sink               req_ch,
   output nirt_pkg::queue_out_type q_out,
   input  logic                   q_pop
);

   nirt_pkg::tick_item_type entry_ff [nirt_pkg::QUEUE_DEPTH];

   logic [nirt_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nirt_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nirt_pkg::QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                                 push;
   logic                                 pop;
   nirt_pkg::tick_item_type              incoming;

   function automatic logic [nirt_pkg::QUEUE_PTR_WIDTH-1:0] ptr_next(
      input logic [nirt_pkg::QUEUE_PTR_WIDTH-1:0] p);
      if (p == nirt_pkg::QUEUE_PTR_WIDTH'(nirt_pkg::QUEUE_DEPTH - 1))
         return '0;
      return p + 1'b1;
   endfunction

   assign req_ch.ready = (count_ff != nirt_pkg::QUEUE_CNT_WIDTH'(nirt_pkg::QUEUE_DEPTH));
   assign push         = req_ch.valid & req_ch.ready;
   assign pop          = q_pop & (count_ff != '0);

   // classify: a tick either carries a start request or is a plain tick
   assign incoming.start     = req_ch.start_req;
   assign incoming.data_byte = req_ch.data_byte;

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nirt_pkg::QUEUE_CNT_WIDTH'(nirt_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

endmodule

[design/nirt_back.sv]
// Back end: NEC frame sequencer, one queued tick per step, with registered result.
module nirt_back #(
   parameter int TIMER_WIDTH = nirt_pkg::DEFAULT_TIMER_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nirt_pkg::csr_type       csr,
   input  nirt_pkg::queue_out_type q_in,
   output logic                    q_pop,
   nirt_rsp_if.source              rsp_ch
);

   localparam int EXT_WIDTH = (TIMER_WIDTH > 14) ? TIMER_WIDTH : 14;

   nirt_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [TIMER_WIDTH-1:0]               tick_ff, tick_in, cur_tick;
   logic [nirt_pkg::BIT_INDEX_WIDTH-1:0] bit_index_ff, bit_index_in, cur_bit_index;
   logic [nirt_pkg::FRAME_BITS-1:0]      frame_bits_ff, frame_bits_in, cur_frame_bits;
   logic [7:0]                           frames_sent_ff, frames_sent_in, cur_frames_sent;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 carrier_ff, carrier_in;
   logic                                 busy_ff, busy_in;

   logic                   step;
   logic                   go;
   logic                   active;
   logic [13:0]            dur_raw;
   logic [TIMER_WIDTH-1:0] dur_len;
   logic [TIMER_WIDTH:0]   tick_plus;
   logic                   phase_done;
   logic [8:0]             frames_plus;

   function automatic logic [TIMER_WIDTH-1:0] eff_len(input logic [13:0] raw);
      logic [EXT_WIDTH-1:0]   ext;
      logic [TIMER_WIDTH-1:0] d;
      ext = EXT_WIDTH'(raw);
      d   = ext[TIMER_WIDTH-1:0];
      return (d == '0) ? TIMER_WIDTH'(1) : d;
   endfunction

   // step the sequencer when a tick is queued and the result slot is free or draining
   assign step  = q_in.valid & (~rsp_valid_ff | rsp_ch.ready);
   assign q_pop = step;
   assign go    = (phase_ff == nirt_pkg::PH_IDLE) & q_in.item.start
                & (csr.repeat_count != 8'd0);

   // phase seen by this tick: an idle start with nonzero repeats opens the header mark
   always_comb begin
      cur_phase       = phase_ff;
      cur_tick        = tick_ff;
      cur_bit_index   = bit_index_ff;
      cur_frame_bits  = frame_bits_ff;
      cur_frames_sent = frames_sent_ff;
      if (go) begin
         cur_phase       = nirt_pkg::PH_HDR_MARK;
         cur_tick        = '0;
         cur_bit_index   = '0;
         cur_frames_sent = '0;
         cur_frame_bits  = {~q_in.item.data_byte, q_in.item.data_byte,
                            ~csr.device_address, csr.device_address};
      end
      active = (cur_phase != nirt_pkg::PH_IDLE);
   end

   always_comb begin
      case (cur_phase)
         nirt_pkg::PH_HDR_MARK:  dur_raw = csr.header_mark_ticks;
         nirt_pkg::PH_HDR_SPACE: dur_raw = csr.header_space_ticks;
         nirt_pkg::PH_BIT_MARK:  dur_raw = csr.bit_mark_ticks;
         nirt_pkg::PH_BIT_SPACE: dur_raw = cur_frame_bits[cur_bit_index]
                                         ? csr.one_space_ticks : csr.zero_space_ticks;
         nirt_pkg::PH_END_MARK:  dur_raw = csr.bit_mark_ticks;
         default:                dur_raw = csr.gap_ticks;
      endcase
      dur_len     = eff_len(dur_raw);
      tick_plus   = {1'b0, cur_tick} + 1'b1;
      phase_done  = (tick_plus >= {1'b0, dur_len});
      frames_plus = {1'b0, cur_frames_sent} + 1'b1;
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      tick_in        = tick_ff;
      bit_index_in   = bit_index_ff;
      frame_bits_in  = frame_bits_ff;
      frames_sent_in = frames_sent_ff;
      if (step && active) begin
         phase_in       = cur_phase;
         bit_index_in   = cur_bit_index;
         frame_bits_in  = cur_frame_bits;
         frames_sent_in = cur_frames_sent;
         if (!phase_done) begin
            tick_in = tick_plus[TIMER_WIDTH-1:0];
         end else begin
            tick_in = '0;
            case (cur_phase)
               nirt_pkg::PH_HDR_MARK:  phase_in = nirt_pkg::PH_HDR_SPACE;
               nirt_pkg::PH_HDR_SPACE: phase_in = nirt_pkg::PH_BIT_MARK;
               nirt_pkg::PH_BIT_MARK:  phase_in = nirt_pkg::PH_BIT_SPACE;
               nirt_pkg::PH_BIT_SPACE: begin
                  if (cur_bit_index != nirt_pkg::BIT_INDEX_WIDTH'(nirt_pkg::FRAME_BITS - 1)) begin
                     bit_index_in = cur_bit_index + 1'b1;
                     phase_in     = nirt_pkg::PH_BIT_MARK;
                  end else begin
                     phase_in = nirt_pkg::PH_END_MARK;
                  end
               end
               nirt_pkg::PH_END_MARK:  phase_in = nirt_pkg::PH_GAP;
               default: begin
                  bit_index_in = '0;
                  if (frames_plus >= {1'b0, csr.repeat_count}) begin
                     phase_in       = nirt_pkg::PH_IDLE;
                     frames_sent_in = '0;
                  end else begin
                     phase_in       = nirt_pkg::PH_HDR_MARK;
                     frames_sent_in = frames_plus[7:0];
                  end
               end
            endcase
         end
      end
   end

   // result of this tick
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      carrier_in   = carrier_ff;
      busy_in      = busy_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         busy_in      = active;
         carrier_in   = cur_phase inside {nirt_pkg::PH_HDR_MARK, nirt_pkg::PH_BIT_MARK,
                                          nirt_pkg::PH_END_MARK};
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= nirt_pkg::PH_IDLE;
         tick_ff        <= '0;
         bit_index_ff   <= '0;
         frame_bits_ff  <= '0;
         frames_sent_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         tick_ff        <= tick_in;
         bit_index_ff   <= bit_index_in;
         frame_bits_ff  <= frame_bits_in;
         frames_sent_ff <= frames_sent_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carrier_ff <= carrier_in;
      busy_ff    <= busy_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.carrier_on = carrier_ff;
   assign rsp_ch.busy_res   = busy_ff;

   a_carrier_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!carrier_ff || busy_ff))
      else $error("carrier without busy");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == nirt_pkg::PH_IDLE) |-> (tick_ff == '0 && frames_sent_ff == '0))
      else $error("idle with stale counters");

   a_header_bit0: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == nirt_pkg::PH_HDR_MARK || phase_ff == nirt_pkg::PH_HDR_SPACE)
      |-> (bit_index_ff == '0))
      else $error("header phase with nonzero bit index");

   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("stepped tick left no result");

endmodule

[design/nec_ir_frame_transmitter_core.sv]
// Top level: NEC IR frame transmitter with config registers, tick queue and frame sequencer.
// Throughput: one tick transaction per cycle, sustained, with both sides streaming.
// Path: an accepted tick is held in the tick queue, stepped by the sequencer and its result
//   registered. The sequencer steps one queued tick per cycle unless the result register
//   is full and not taken; the result register and queue let either side stall alone.
// Reset (synchronous, active high) clears queue, result, sequencer, regs.
module nec_ir_frame_transmitter_core #(
   parameter int TIMER_WIDTH = nirt_pkg::DEFAULT_TIMER_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   nirt_req_if.sink                             req_ch,
   nirt_rsp_if.source                           rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [nirt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [nirt_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   nirt_pkg::csr_type       csr_ff, csr_in;
   nirt_pkg::queue_out_type q_out;
   logic                    q_pop;

   // Register file: durations act at once, the address is sampled at each start.
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            nirt_pkg::CSR_REPEAT_COUNT: csr_in.repeat_count       = csr_wr_data[7:0];
            nirt_pkg::CSR_DEVICE_ADDR:  csr_in.device_address     = csr_wr_data[7:0];
            nirt_pkg::CSR_HDR_MARK:     csr_in.header_mark_ticks  = csr_wr_data[13:0];
            nirt_pkg::CSR_HDR_SPACE:    csr_in.header_space_ticks = csr_wr_data[13:0];
            nirt_pkg::CSR_BIT_MARK:     csr_in.bit_mark_ticks     = csr_wr_data[13:0];
            nirt_pkg::CSR_ONE_SPACE:    csr_in.one_space_ticks    = csr_wr_data[13:0];
            nirt_pkg::CSR_ZERO_SPACE:   csr_in.zero_space_ticks   = csr_wr_data[13:0];
            nirt_pkg::CSR_GAP:          csr_in.gap_ticks          = csr_wr_data[13:0];
            default:                    csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.repeat_count       <= nirt_pkg::RST_REPEAT_COUNT;
         csr_ff.device_address     <= nirt_pkg::RST_DEVICE_ADDR;
         csr_ff.header_mark_ticks  <= nirt_pkg::RST_HDR_MARK;
         csr_ff.header_space_ticks <= nirt_pkg::RST_HDR_SPACE;
         csr_ff.bit_mark_ticks     <= nirt_pkg::RST_BIT_MARK;
         csr_ff.one_space_ticks    <= nirt_pkg::RST_ONE_SPACE;
         csr_ff.zero_space_ticks   <= nirt_pkg::RST_ZERO_SPACE;
         csr_ff.gap_ticks          <= nirt_pkg::RST_GAP;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Front: take in tick transactions and hold them in the queue.
   nirt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_out  (q_out),
      .q_pop  (q_pop)
   );

   // Back: advance the frame sequencer one tick per step and register the result.
   nirt_back #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr_ff),
      .q_in   (q_out),
      .q_pop  (q_pop),
      .rsp_ch (rsp_ch)
   );

endmodule
